// File: rtl/nearest_frontier_select_assert.svh
// assertion macros used by the top level of the frontier selector
`ifndef NEAREST_FRONTIER_SELECT_ASSERT_SVH
`define NEAREST_FRONTIER_SELECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NFS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frontier selector check failed");

// next-cycle implication, checked outside reset
`define NFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frontier selector check failed");

`endif

// File: rtl/nfs_pkg.sv
// shared types, codes and constants of the frontier selector
`default_nettype none

package nfs_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int CMD_DEPTH_DEF  = 4;
   localparam int RSP_DEPTH_DEF  = 4;

   localparam int TOL_W = 50;
   localparam logic [TOL_W-1:0] GOAL_TOL_RESET     = 50'd5898;
   localparam logic [TOL_W-1:0] FRONTIER_TOL_RESET = 50'd5898;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_TOL     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONTIER_TOL = 1'b1;

   localparam logic [1:0] FUNC_POSE  = 2'd0;
   localparam logic [1:0] FUNC_POINT = 2'd1;
   localparam logic [1:0] FUNC_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      OP_POSE,
      OP_POINT,
      OP_EMPTY,
      OP_ORPHAN_LAST
   } op_type;

   typedef struct packed {
      op_type op;
      logic   first;
      logic   last;
   } cmd_ctrl_type;

   typedef struct packed {
      logic found;
      logic scan_empty;
   } rsp_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/nfs_queue.sv
// small first-in first-out queue of flat words
`default_nettype none

module nfs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = (count_ff == FULL_CNT);
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      rdata   = rdata_ff;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
      // head word of the next cycle; a word landing in the head slot bypasses the array
      if (do_push && (wr_ptr_ff == rd_ptr_in)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem_ff[rd_ptr_in];
      end
   end

endmodule

`default_nettype wire

// File: rtl/nfs_front.sv
// front end: takes input words, tracks pose and scan framing, issues commands
`default_nettype none

module nfs_front #(
   parameter int COORD_BITS = nfs_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [1:0]            req_func,
   input  wire logic [COORD_BITS-1:0] req_coord_x,
   input  wire logic [COORD_BITS-1:0] req_coord_y,
   input  wire logic                  req_last_point,
   output logic                       cmd_push,
   output nfs_pkg::cmd_ctrl_type      cmd_ctrl,
   output logic [COORD_BITS-1:0]      cmd_x,
   output logic [COORD_BITS-1:0]      cmd_y,
   input  wire logic                  cmd_full
);

   import nfs_pkg::*;

   logic pose_valid_ff, pose_valid_in;
   logic scan_open_ff, scan_open_in;
   logic accept;
   logic issue;

   always_comb begin
      req_full      = cmd_full;
      accept        = req_push && !cmd_full;
      issue         = 1'b0;
      cmd_ctrl      = '{op: OP_POSE, first: 1'b0, last: req_last_point};
      cmd_x         = req_coord_x;
      cmd_y         = req_coord_y;
      pose_valid_in = pose_valid_ff;
      scan_open_in  = scan_open_ff;

      unique case (req_func)
         FUNC_POSE: begin
            issue         = 1'b1;
            cmd_ctrl.op   = OP_POSE;
            pose_valid_in = 1'b1;
         end
         FUNC_POINT: begin
            if (pose_valid_ff) begin
               issue          = 1'b1;
               cmd_ctrl.op    = OP_POINT;
               cmd_ctrl.first = !scan_open_ff;
               scan_open_in   = !req_last_point;
            end else if (req_last_point) begin
               // scan ends before any pose: report nothing found
               issue       = 1'b1;
               cmd_ctrl.op = OP_ORPHAN_LAST;
            end
         end
         FUNC_EMPTY: begin
            issue        = 1'b1;
            cmd_ctrl.op  = OP_EMPTY;
            scan_open_in = 1'b0;
         end
         default: begin
            issue = 1'b0;
         end
      endcase

      cmd_push = accept && issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_valid_ff <= 1'b0;
         scan_open_ff  <= 1'b0;
      end else if (accept) begin
         pose_valid_ff <= pose_valid_in;
         scan_open_ff  <= scan_open_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/nfs_back.sv
// back end: squared distances, tolerance tests and running nearest choice
`default_nettype none

module nfs_back #(
   parameter int COORD_BITS = nfs_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [nfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nfs_pkg::TOL_W-1:0]     csr_data,
   input  wire logic                          cmd_empty,
   output logic                               cmd_pop,
   input  wire nfs_pkg::cmd_ctrl_type         cmd_ctrl,
   input  wire logic [COORD_BITS-1:0]         cmd_x,
   input  wire logic [COORD_BITS-1:0]         cmd_y,
   output logic                               res_push,
   output nfs_pkg::rsp_ctrl_type              res_ctrl,
   output logic [COORD_BITS-1:0]              res_goal_x,
   output logic [COORD_BITS-1:0]              res_goal_y,
   input  wire logic                          res_full
);

   import nfs_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int SQ_W   = 2 * CB;
   localparam int DIST_W = SQ_W + 1;
   localparam int CMP_W  = (DIST_W > TOL_W) ? DIST_W : TOL_W;

   // magnitude of a - b; the difference never reaches -2^CB so CB bits hold it
   function automatic logic [CB-1:0] mag_diff(input logic [CB-1:0] a,
                                              input logic [CB-1:0] b);
      logic signed [CB:0] d;
      logic signed [CB:0] n;
      d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
      n = -d;
      return d[CB] ? n[CB-1:0] : d[CB-1:0];
   endfunction

   logic [TOL_W-1:0] goal_tol_ff, frontier_tol_ff;

   // stage 1: command register, pose and previous-frontier snapshot
   logic         s1_valid_ff, s1_valid_in;
   cmd_ctrl_type s1_ctrl_ff;
   logic [CB-1:0] s1_x_ff, s1_y_ff;
   logic [CB-1:0] robot_x_ff, robot_y_ff;
   logic [CB-1:0] previous_x_ff, previous_y_ff;
   logic [CB-1:0] prev_x, prev_y;
   logic [CB-1:0] mag_rx, mag_ry, mag_fx, mag_fy;
   logic [SQ_W-1:0] sq_rx, sq_ry, sq_fx, sq_fy;
   logic         s1_hazard, s1_fire, s1_load;

   // stage 2: squares registered, sums, compares and choice
   logic         s2_valid_ff, s2_valid_in;
   cmd_ctrl_type s2_ctrl_ff;
   logic [CB-1:0] s2_x_ff, s2_y_ff;
   logic [SQ_W-1:0] sq_rx_ff, sq_ry_ff, sq_fx_ff, sq_fy_ff;
   logic [DIST_W-1:0] dist_r, dist_f;
   logic         s2_emits, s2_ready, s2_fire;
   logic         best_eff, qualify;

   logic [CB-1:0] chosen_x_ff, chosen_y_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic         best_valid_ff;

   always_comb begin
      s2_emits = (s2_ctrl_ff.op != OP_POINT) || s2_ctrl_ff.last;
      s2_ready = !s2_valid_ff || !s2_emits || !res_full;
      s2_fire  = s2_valid_ff && s2_ready;

      // a scan's first point snapshots the final choice of the scan before,
      // so it waits while a point still sits in stage 2
      s1_hazard = (s1_ctrl_ff.op == OP_POINT) && s1_ctrl_ff.first
                  && s2_valid_ff && (s2_ctrl_ff.op == OP_POINT);
      s1_fire   = s1_valid_ff && s2_ready && !s1_hazard;
      s1_load   = !s1_valid_ff || s1_fire;
      cmd_pop   = s1_load;
      s1_valid_in = s1_load ? !cmd_empty : s1_valid_ff;

      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_fire && (s1_ctrl_ff.op != OP_POSE);
      end

      prev_x = s1_ctrl_ff.first ? chosen_x_ff : previous_x_ff;
      prev_y = s1_ctrl_ff.first ? chosen_y_ff : previous_y_ff;

      mag_rx = mag_diff(s1_x_ff, robot_x_ff);
      mag_ry = mag_diff(s1_y_ff, robot_y_ff);
      mag_fx = mag_diff(s1_x_ff, prev_x);
      mag_fy = mag_diff(s1_y_ff, prev_y);
      sq_rx  = SQ_W'(mag_rx) * SQ_W'(mag_rx);
      sq_ry  = SQ_W'(mag_ry) * SQ_W'(mag_ry);
      sq_fx  = SQ_W'(mag_fx) * SQ_W'(mag_fx);
      sq_fy  = SQ_W'(mag_fy) * SQ_W'(mag_fy);

      dist_r   = DIST_W'(sq_rx_ff) + DIST_W'(sq_ry_ff);
      dist_f   = DIST_W'(sq_fx_ff) + DIST_W'(sq_fy_ff);
      best_eff = s2_ctrl_ff.first ? 1'b0 : best_valid_ff;
      qualify  = (s2_ctrl_ff.op == OP_POINT)
                 && (!best_eff || (dist_r < best_dist_ff))
                 && (CMP_W'(dist_r) > CMP_W'(goal_tol_ff))
                 && (CMP_W'(dist_f) > CMP_W'(frontier_tol_ff));

      res_push            = s2_fire && s2_emits;
      res_ctrl.found      = (s2_ctrl_ff.op == OP_POINT) && (best_eff || qualify);
      res_ctrl.scan_empty = (s2_ctrl_ff.op == OP_EMPTY);
      res_goal_x          = qualify ? s2_x_ff : chosen_x_ff;
      res_goal_y          = qualify ? s2_y_ff : chosen_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_tol_ff     <= GOAL_TOL_RESET;
         frontier_tol_ff <= FRONTIER_TOL_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_GOAL_TOL) begin
            goal_tol_ff <= csr_data;
         end else if (csr_index == CSR_FRONTIER_TOL) begin
            frontier_tol_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         chosen_x_ff   <= '0;
         chosen_y_ff   <= '0;
         robot_x_ff    <= '0;
         robot_y_ff    <= '0;
         previous_x_ff <= '0;
         previous_y_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_fire) begin
            if (s1_ctrl_ff.op == OP_POSE) begin
               robot_x_ff <= s1_x_ff;
               robot_y_ff <= s1_y_ff;
            end else if (s1_ctrl_ff.op == OP_POINT) begin
               previous_x_ff <= prev_x;
               previous_y_ff <= prev_y;
            end
         end
         if (s2_fire && (s2_ctrl_ff.op == OP_POINT)) begin
            best_valid_ff <= best_eff || qualify;
            if (qualify) begin
               chosen_x_ff <= s2_x_ff;
               chosen_y_ff <= s2_y_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ctrl_ff <= cmd_ctrl;
         s1_x_ff    <= cmd_x;
         s1_y_ff    <= cmd_y;
      end
      if (s2_ready && s1_fire) begin
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         sq_rx_ff   <= sq_rx;
         sq_ry_ff   <= sq_ry;
         sq_fx_ff   <= sq_fx;
         sq_fy_ff   <= sq_fy;
      end
      if (s2_fire && qualify) begin
         best_dist_ff <= dist_r;
      end
   end

endmodule

`default_nettype wire

// File: rtl/nearest_frontier_select.sv
// Nearest frontier selector, top level.
// Input words go in through req_push/req_full: func 0 sets the robot pose,
// func 1 is a candidate point (req_last_point closes the scan), func 2 is an
// empty scan. Each closed scan, and each empty scan, gives one result word on
// the rsp_ side, shown while rsp_empty is low and taken with rsp_pop.
// The chosen point is the nearest one to the robot that lies beyond both the
// goal tolerance from the robot and the frontier tolerance from the previous
// choice; both tolerances are squared, 16 fraction bits, set over csr_.
// Throughput: one word per cycle while the result queue has room; the first
// point of a scan that directly follows another point waits while that point
// is in the compare stage, since its previous-frontier snapshot needs the
// choice made by that point.
// A command queue splits the front end from the distance pipeline and a
// result queue holds finished words, so a stalled receiver only backs up
// into req_full once both queues have filled.
// Reset empties both queues, clears pose, scan and choice to zero and loads
// both tolerances with 5898.
`default_nettype none

module nearest_frontier_select #(
   parameter int COORD_BITS = nfs_pkg::COORD_BITS_DEF,
   parameter int CMD_DEPTH  = nfs_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH  = nfs_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [1:0]                    req_func,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_y,
   input  wire logic                          req_last_point,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic                               rsp_found,
   output logic                               rsp_scan_empty,
   output logic signed [COORD_BITS-1:0]       rsp_goal_x,
   output logic signed [COORD_BITS-1:0]       rsp_goal_y,
   input  wire logic                          csr_wr_en,
   input  wire logic [nfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nfs_pkg::TOL_W-1:0]     csr_data
);

   import nfs_pkg::*;

   `include "nearest_frontier_select_assert.svh"

   localparam int CMD_W = $bits(cmd_ctrl_type) + 2 * COORD_BITS;
   localparam int RSP_W = $bits(rsp_ctrl_type) + 2 * COORD_BITS;

   logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_ctrl_type          cmd_ctrl, cmd_rd_ctrl;
   logic [COORD_BITS-1:0] cmd_x, cmd_y, cmd_rd_x, cmd_rd_y;
   logic [CMD_W-1:0]      cmd_wdata, cmd_rdata;

   logic                  res_push, res_full;
   rsp_ctrl_type          res_ctrl, rsp_ctrl;
   logic [COORD_BITS-1:0] res_goal_x, res_goal_y;
   logic [RSP_W-1:0]      res_wdata, rsp_rdata;

   nfs_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_last_point (req_last_point),
      .cmd_push       (cmd_push),
      .cmd_ctrl       (cmd_ctrl),
      .cmd_x          (cmd_x),
      .cmd_y          (cmd_y),
      .cmd_full       (cmd_full)
   );

   assign cmd_wdata = {cmd_ctrl, cmd_x, cmd_y};

   nfs_queue #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   assign cmd_rd_ctrl = cmd_rdata[CMD_W-1 -: $bits(cmd_ctrl_type)];
   assign cmd_rd_x    = cmd_rdata[2*COORD_BITS-1 -: COORD_BITS];
   assign cmd_rd_y    = cmd_rdata[COORD_BITS-1:0];

   nfs_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_ctrl   (cmd_rd_ctrl),
      .cmd_x      (cmd_rd_x),
      .cmd_y      (cmd_rd_y),
      .res_push   (res_push),
      .res_ctrl   (res_ctrl),
      .res_goal_x (res_goal_x),
      .res_goal_y (res_goal_y),
      .res_full   (res_full)
   );

   assign res_wdata = {res_ctrl, res_goal_x, res_goal_y};

   nfs_queue #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_ctrl       = rsp_rdata[RSP_W-1 -: $bits(rsp_ctrl_type)];
   assign rsp_found      = rsp_ctrl.found;
   assign rsp_scan_empty = rsp_ctrl.scan_empty;
   assign rsp_goal_x     = rsp_rdata[2*COORD_BITS-1 -: COORD_BITS];
   assign rsp_goal_y     = rsp_rdata[COORD_BITS-1:0];

   // the pipeline never hands a word to a full queue
   `NFS_ASSERT_IMPLY(a_cmd_no_overflow, cmd_push, !cmd_full)
   `NFS_ASSERT_IMPLY(a_rsp_no_overflow, res_push, !res_full)
   // an empty-scan word never reports a find
   `NFS_ASSERT_IMPLY(a_empty_not_found, res_push && res_ctrl.scan_empty, !res_ctrl.found)

endmodule

`default_nettype wire

// File: bench/nearest_frontier_select_test.sv
// self-checking testbench of the nearest frontier selector, queue-level stimulus and checks
`timescale 1ns / 1ps

module nearest_frontier_select_test;
   import nfs_pkg::*;

   localparam int COORD_W = COORD_BITS_DEF;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [TOL_W-1:0] TOL_MAX = '1;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int WORD_TARGET = 550;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      found;
      logic      scan_empty;
      coord_type goal_x;
      coord_type goal_y;
   } goal_word_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [1:0]           req_func;
   coord_type            req_coord_x;
   coord_type            req_coord_y;
   logic                 req_last_point;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic                 rsp_found;
   logic                 rsp_scan_empty;
   coord_type            rsp_goal_x;
   coord_type            rsp_goal_y;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TOL_W-1:0]     csr_data;

   nearest_frontier_select dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_last_point (req_last_point),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_found      (rsp_found),
      .rsp_scan_empty (rsp_scan_empty),
      .rsp_goal_x     (rsp_goal_x),
      .rsp_goal_y     (rsp_goal_y),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #10 clock = ~clock;

   // selector state as the testbench sees it
   coord_type        robot_x_q, robot_y_q;
   coord_type        chosen_x_q, chosen_y_q;
   coord_type        prev_x_q, prev_y_q;
   logic             pose_seen, best_held, scan_live;
   longint unsigned  best_range_sq;
   logic [TOL_W-1:0] goal_tol, frontier_tol;

   goal_word_type goals_due[$];
   int            goal_mismatches = 0;
   int            words_taken = 0;
   int            cycle_count = 0;
   int            rsp_hold_left = 0;
   bit            req_gaps_on = 1'b1;
   bit            rsp_gaps_on = 1'b1;

   function automatic longint unsigned span_sq(coord_type ax, coord_type ay,
                                               coord_type bx, coord_type by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return $unsigned(dx * dx + dy * dy);
   endfunction

   function automatic void expect_goal(logic found, logic scan_empty);
      goal_word_type w;
      w.found      = found;
      w.scan_empty = scan_empty;
      w.goal_x     = chosen_x_q;
      w.goal_y     = chosen_y_q;
      goals_due    = {goals_due, w};
   endfunction

   function automatic void advance_selector(logic [1:0] func, coord_type px, coord_type py,
                                            logic last);
      longint unsigned dr, df;
      case (func)
         FUNC_POSE: begin
            robot_x_q = px;
            robot_y_q = py;
            pose_seen = 1'b1;
         end
         FUNC_EMPTY: begin
            scan_live = 1'b0;
            expect_goal(1'b0, 1'b1);
         end
         FUNC_POINT: begin
            if (!pose_seen) begin
               if (last)
                  expect_goal(1'b0, 1'b0);
            end else begin
               if (!scan_live) begin
                  prev_x_q  = chosen_x_q;
                  prev_y_q  = chosen_y_q;
                  best_held = 1'b0;
                  scan_live = 1'b1;
               end
               dr = span_sq(robot_x_q, robot_y_q, px, py);
               df = span_sq(prev_x_q, prev_y_q, px, py);
               if ((!best_held || dr < best_range_sq) && dr > goal_tol && df > frontier_tol)
               begin
                  chosen_x_q    = px;
                  chosen_y_q    = py;
                  best_range_sq = dr;
                  best_held     = 1'b1;
               end
               if (last) begin
                  scan_live = 1'b0;
                  expect_goal(best_held, 1'b0);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic coord_type jitter(coord_type base, int span);
      return base + coord_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [TOL_W-1:0] rand_tol();
      int unsigned r;
      r = $urandom_range(0, 3000);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return TOL_W'({$urandom, $urandom});
         default: return TOL_W'(r * r);
      endcase
   endfunction

   // push stays high after acceptance so back-to-back words go in without a gap
   task automatic send_word(logic [1:0] func, coord_type px, coord_type py, logic last);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_func       <= func;
      req_coord_x    <= px;
      req_coord_y    <= py;
      req_last_point <= last;
      do @(posedge clock); while (req_full);
      advance_selector(func, px, py, last);
      if (func != FUNC_UNUSED)
         words_taken++;
   endtask

   task automatic send_scan(int n, int span, bit abandon);
      bit near_prev;
      for (int i = 0; i < n; i++) begin
         near_prev = ($urandom_range(0, 3) == 0);
         if (abandon && i == n - 1)
            send_word(FUNC_EMPTY, coord_type'($urandom), coord_type'($urandom), 1'($urandom));
         else if (near_prev)
            send_word(FUNC_POINT, jitter(chosen_x_q, span), jitter(chosen_y_q, span),
                      i == n - 1);
         else
            send_word(FUNC_POINT, jitter(robot_x_q, span), jitter(robot_y_q, span),
                      i == n - 1);
      end
   endtask

   // words without a result may still sit in the pipe, so drain a while longer
   task automatic wait_idle();
      req_push <= 1'b0;
      while (goals_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_tolerances(logic [TOL_W-1:0] goal, logic [TOL_W-1:0] frontier);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GOAL_TOL;
      csr_data  <= goal;
      @(posedge clock);
      csr_index <= CSR_FRONTIER_TOL;
      csr_data  <= frontier;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      goal_tol     = goal;
      frontier_tol = frontier;
   endtask

   task automatic test_points_before_pose();
      send_word(FUNC_POINT, 24'sd5, 24'sd5, 1'b0);
      send_word(FUNC_POINT, -24'sd8388608, 24'sd8388607, 1'b1);
      send_word(FUNC_UNUSED, 24'sd1, -24'sd1, 1'b1);
      send_word(FUNC_EMPTY, -24'sd1, 24'sd0, 1'b0);
   endtask

   task automatic test_directed_scans();
      send_word(FUNC_POSE, 24'sd0, 24'sd0, 1'b0);
      // far corners, one inside the goal radius, then a tie that must not replace
      send_word(FUNC_POINT, 24'sd8388607, 24'sd8388607, 1'b0);
      send_word(FUNC_POINT, -24'sd8388608, -24'sd8388608, 1'b0);
      send_word(FUNC_POINT, 24'sd10, 24'sd10, 1'b0);
      send_word(FUNC_POINT, 24'sd100, 24'sd0, 1'b0);
      send_word(FUNC_POINT, 24'sd0, 24'sd100, 1'b0);
      send_word(FUNC_POINT, 24'sd0, -24'sd100, 1'b1);
      // too close to the previous frontier, then a valid one
      send_word(FUNC_POINT, 24'sd110, 24'sd0, 1'b0);
      send_word(FUNC_POINT, -24'sd120, 24'sd0, 1'b1);
      // nothing qualifies, previous goal is kept
      send_word(FUNC_POINT, 24'sd5, 24'sd5, 1'b1);
      // pose moves while the scan is open
      send_word(FUNC_POINT, 24'sd3000, 24'sd0, 1'b0);
      send_word(FUNC_POSE, 24'sd3000, 24'sd0, 1'b0);
      send_word(FUNC_POINT, 24'sd3100, 24'sd0, 1'b1);
      // scan abandoned by an empty scan word
      send_word(FUNC_POINT, -24'sd500, -24'sd500, 1'b0);
      send_word(FUNC_EMPTY, 24'sd0, 24'sd0, 1'b1);
      send_word(FUNC_UNUSED, -24'sd8388608, 24'sd8388607, 1'b0);
   endtask

   task automatic test_tolerance_extremes();
      wait_idle();
      set_tolerances('0, '0);
      send_word(FUNC_POINT, robot_x_q, robot_y_q, 1'b0);
      send_word(FUNC_POINT, chosen_x_q, chosen_y_q, 1'b0);
      send_word(FUNC_POINT, robot_x_q + 24'sd1, robot_y_q, 1'b1);
      wait_idle();
      set_tolerances(TOL_MAX, TOL_MAX);
      send_word(FUNC_POINT, coord_type'($urandom), coord_type'($urandom), 1'b0);
      send_word(FUNC_POINT, 24'sd8388607, -24'sd8388608, 1'b1);
      wait_idle();
      set_tolerances(GOAL_TOL_RESET, FRONTIER_TOL_RESET);
   endtask

   task automatic test_backpressure();
      wait_idle();
      req_gaps_on   = 1'b0;
      rsp_hold_left = 300;
      repeat (30) send_scan(1, 2048, 1'b0);
      req_gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (4) begin
         send_scan($urandom_range(1, 4), 4096, 1'b0);
         wait_idle();
      end
   endtask

   task automatic test_random_traffic();
      int choice;
      while (words_taken < WORD_TARGET) begin
         if ($urandom_range(0, 11) == 0) begin
            wait_idle();
            set_tolerances(rand_tol(), rand_tol());
            req_gaps_on = $urandom_range(0, 2) != 0;
            rsp_gaps_on = $urandom_range(0, 2) != 0;
         end
         choice = $urandom_range(0, 99);
         if (choice < 10) begin
            if ($urandom_range(0, 2) == 0)
               send_word(FUNC_POSE, coord_type'($urandom), coord_type'($urandom), 1'($urandom));
            else
               send_word(FUNC_POSE, jitter(robot_x_q, 8192), jitter(robot_y_q, 8192),
                         1'($urandom));
         end else if (choice < 85) begin
            send_scan($urandom_range(1, 8), ($urandom_range(0, 1) != 0) ? 2048 : 65536,
                      $urandom_range(0, 9) == 0);
         end else if (choice < 92) begin
            send_word(FUNC_EMPTY, coord_type'($urandom), coord_type'($urandom), 1'($urandom));
         end else if (choice < 96) begin
            send_word(FUNC_UNUSED, coord_type'($urandom), coord_type'($urandom), 1'($urandom));
         end else begin
            send_word(FUNC_POINT, coord_type'($urandom), coord_type'($urandom), 1'($urandom));
         end
      end
   endtask

   // result side: random stall per word plus an optional long hold-off
   initial begin : rsp_drain
      int stall;
      rsp_pop <= 1'b0;
      @(posedge clock);
      forever begin
         stall = rsp_gaps_on ? $urandom_range(0, 13) : 0;
         if (stall > 0 || rsp_hold_left > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold_left > 0) begin
               @(posedge clock);
               rsp_hold_left--;
            end
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   always @(posedge clock) begin : check_goals
      goal_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (goals_due.size() == 0) begin
            goal_mismatches++;
            if (goal_mismatches <= 10)
               $display("unexpected goal word: found %0b empty %0b x %0d y %0d",
                        rsp_found, rsp_scan_empty, rsp_goal_x, rsp_goal_y);
         end else begin
            want = goals_due.pop_front();
            if (rsp_found !== want.found || rsp_scan_empty !== want.scan_empty ||
                rsp_goal_x !== want.goal_x || rsp_goal_y !== want.goal_y) begin
               goal_mismatches++;
               if (goal_mismatches <= 10) begin
                  $display("goal word mismatch: expected found %0b empty %0b x %0d y %0d,",
                           want.found, want.scan_empty, want.goal_x, want.goal_y);
                  $display("   got found %0b empty %0b x %0d y %0d",
                           rsp_found, rsp_scan_empty, rsp_goal_x, rsp_goal_y);
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[nearest_frontier_select] ERROR");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_func       <= FUNC_POSE;
      req_coord_x    <= '0;
      req_coord_y    <= '0;
      req_last_point <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_GOAL_TOL;
      csr_data       <= '0;
      robot_x_q = '0;  robot_y_q = '0;
      chosen_x_q = '0; chosen_y_q = '0;
      prev_x_q = '0;   prev_y_q = '0;
      pose_seen = 1'b0;
      best_held = 1'b0;
      scan_live = 1'b0;
      best_range_sq = 0;
      goal_tol     = GOAL_TOL_RESET;
      frontier_tol = FRONTIER_TOL_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_points_before_pose();
      test_directed_scans();
      test_tolerance_extremes();
      test_backpressure();
      test_sender_pause();
      test_random_traffic();
      wait_idle();

      if (goal_mismatches == 0 && goals_due.size() == 0)
         $display("[nearest_frontier_select] OK");
      else
         $display("[nearest_frontier_select] ERROR");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/nfs_pkg.sv
rtl/nfs_queue.sv
rtl/nfs_front.sv
rtl/nfs_back.sv
rtl/nearest_frontier_select.sv
bench/nearest_frontier_select_test.sv
